### rtl/ksb_pkg.sv
`default_nettype none

package ksb_pkg;

    localparam int KEY_W     = 8;
    localparam int ID_W      = 8;
    localparam int STAMP_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 104;

    // Command codes carried in s_tuser.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] order_stamp;
        logic [STAMP_W-1:0] request_stamp;
        logic [ID_W-1:0]    assistant_id;
        logic [ID_W-1:0]    store_id;
        logic               available;
        logic [ID_W-1:0]    product_id;
        logic [ID_W-1:0]    client_id;
    } rec_t;

    typedef struct packed {
        logic load;       // latch a new item and restart the scan
        logic scan;       // advance the scan by one slot
        logic put_write;  // store the record in the slot under the scan pointer
        logic take_hit;   // free the compared slot and return its record
        logic miss;       // return a failure result
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic slot_free;  // slot under the scan pointer is free
        logic scan_last;  // scan pointer sits on the last slot
        logic rd_vld;     // a slot record is waiting in the compare stage
        logic rd_hit;     // that slot is occupied and its key field matches
        logic rd_last;    // that slot is the last one
    } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/ksb_ctrl.sv
`default_nettype none

module ksb_ctrl
    import ksb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire logic      in_cmd,
    output logic           in_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUT  = 2'd1;
    localparam logic [1:0] ST_TAKE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (in_cmd == CMD_TAKE) ? ST_TAKE : ST_PUT;
                end
            end
            ST_PUT: begin
                if (sts.out_free) begin
                    if (sts.slot_free) begin
                        cmd.put_write = 1'b1;
                        state_next    = ST_IDLE;
                    end else if (sts.scan_last) begin
                        cmd.miss   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan = 1'b1;
                    end
                end
            end
            ST_TAKE: begin
                if (sts.out_free) begin
                    if (sts.rd_vld && sts.rd_hit) begin
                        cmd.take_hit = 1'b1;
                        state_next   = ST_IDLE;
                    end else if (sts.rd_vld && sts.rd_last) begin
                        cmd.miss   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result is produced only when the output register can hold it.
    a_result_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_write || cmd.take_hit || cmd.miss) |-> sts.out_free)
        else $error("result issued while output register busy");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.put_write, cmd.take_hit, cmd.miss, cmd.load}))
        else $error("conflicting controller commands");

    // Every item ends with exactly one result and a return to idle.
    a_result_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_write || cmd.take_hit || cmd.miss) |=> in_ready)
        else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

### rtl/ksb_dp.sv
`default_nettype none

module ksb_dp
    import ksb_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire rec_t        in_rec,
    input  wire ctrl_cmd_t   cmd,
    output ctrl_sts_t        sts,
    input  wire logic        out_ready,
    output logic             out_vld,
    output logic             out_ok,
    output logic [SLOT_W-1:0] out_slot,
    output rec_t             out_rec
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    rec_t              mem [SLOTS];
    logic [SLOTS-1:0]  occ_reg;
    logic              cfg_reg;
    logic [KEY_W-1:0]  key_reg;
    rec_t              item_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic              issued_all_reg;
    rec_t              rd_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;
    logic              out_vld_reg;
    logic              out_ok_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    rec_t              out_rec_reg;
    logic [ID_W-1:0]   cmp_field;
    logic              res_load;

    assign cmp_field = cfg_reg ? rd_reg.store_id : rd_reg.client_id;
    assign res_load  = cmd.put_write || cmd.take_hit || cmd.miss;

    assign sts.out_free  = !out_vld_reg || out_ready;
    assign sts.slot_free = !occ_reg[scan_reg];
    assign sts.scan_last = (scan_reg == LAST);
    assign sts.rd_vld    = rd_vld_reg;
    assign sts.rd_hit    = occ_reg[rd_idx_reg] && (cmp_field == key_reg);
    assign sts.rd_last   = (rd_idx_reg == LAST);

    assign out_vld  = out_vld_reg;
    assign out_ok   = out_ok_reg;
    assign out_slot = out_slot_reg;
    assign out_rec  = out_rec_reg;

    // Record store: one write port for puts, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (cmd.put_write) begin
            mem[scan_reg] <= item_reg;
        end
        if (cmd.scan) begin
            rd_reg     <= mem[scan_reg];
            rd_idx_reg <= scan_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= in_key;
            item_reg <= in_rec;
        end
        if (res_load) begin
            out_ok_reg   <= !cmd.miss;
            out_slot_reg <= '0;
            out_rec_reg  <= '0;
            if (cmd.put_write) begin
                out_slot_reg <= SLOT_W'(scan_reg);
            end
            if (cmd.take_hit) begin
                out_slot_reg <= SLOT_W'(rd_idx_reg);
                out_rec_reg  <= rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg        <= '0;
            cfg_reg        <= 1'b1;
            scan_reg       <= '0;
            issued_all_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.put_write) begin
                occ_reg[scan_reg] <= 1'b1;
            end
            if (cmd.take_hit) begin
                occ_reg[rd_idx_reg] <= 1'b0;
            end
            if (cmd.load) begin
                scan_reg       <= '0;
                issued_all_reg <= 1'b0;
                rd_vld_reg     <= 1'b0;
            end else if (cmd.scan) begin
                // The pointer parks on the last slot once every slot is issued.
                rd_vld_reg <= !issued_all_reg;
                if (scan_reg == LAST) begin
                    issued_all_reg <= 1'b1;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (res_load) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    a_put_marks_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put_write |=> occ_reg[$past(scan_reg)])
        else $error("put did not mark its slot occupied");

    a_take_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_hit |-> occ_reg[rd_idx_reg] ##1 !occ_reg[$past(rd_idx_reg)])
        else $error("take did not free an occupied slot");

endmodule

`default_nettype wire

### rtl/keyed_slot_buffer.sv
// Channel   Direction  tdata (low bit first)                                     tuser
// s_        in         key, client_id, product_id, available, store_id,           cmd
//                      assistant_id, request_stamp, order_stamp, zero pad
// m_        out        slot, out_client, out_product, out_available, out_store,  ok
//                      out_assistant, out_request_stamp, out_order_stamp, zero pad
// cfg_wr_   in         match_on_store (bit 0)                                     -
//
// One item is in work at a time; a single slot pointer walks the table one slot per cycle.
// A put finishes at the first free slot and a take at the first occupied slot whose key
// field matches; the take compares one slot behind the pointer, as the record read is
// registered. Reset clears all occupied flags; records are not cleared. A result waiting
// in the output register does not block the next input transfer, but the scan stalls at
// every step while that result waits and m_tready is low.
`default_nettype none

module keyed_slot_buffer
    import ksb_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,   // match_on_store
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // key, client_id, product_id, available, store_id, assistant_id,
    // request_stamp, order_stamp, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,       // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // slot, out_client, out_product, out_available, out_store, out_assistant,
    // out_request_stamp, out_order_stamp, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser        // ok
);

    localparam int REC_W = $bits(rec_t);

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    rec_t              in_rec;
    logic [KEY_W-1:0]  in_key;
    logic [SLOT_W-1:0] out_slot;
    rec_t              out_rec;

    assign in_key               = s_tdata[7:0];
    assign in_rec.client_id     = s_tdata[15:8];
    assign in_rec.product_id    = s_tdata[23:16];
    assign in_rec.available     = s_tdata[24];
    assign in_rec.store_id      = s_tdata[32:25];
    assign in_rec.assistant_id  = s_tdata[40:33];
    assign in_rec.request_stamp = s_tdata[72:41];
    assign in_rec.order_stamp   = s_tdata[104:73];

    assign m_tdata = {(M_TDATA_W - SLOT_W - REC_W)'(0),
                      out_rec.order_stamp, out_rec.request_stamp, out_rec.assistant_id,
                      out_rec.store_id, out_rec.available, out_rec.product_id,
                      out_rec.client_id, out_slot};

    ksb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_key      (in_key),
        .in_rec      (in_rec),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_tready),
        .out_vld     (m_tvalid),
        .out_ok      (m_tuser),
        .out_slot    (out_slot),
        .out_rec     (out_rec)
    );

endmodule

`default_nettype wire

### bench/keyed_slot_buffer_tb.sv
`timescale 1ns / 100ps

module keyed_slot_buffer_tb;
    import ksb_pkg::*;

    localparam int SLOTS = 16;

    typedef struct {
        logic             ok;
        logic [SLOT_W-1:0] slot;
        rec_t             rec;
    } slot_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Shadow of the slot table, updated at each input transfer.
    logic         table_used [SLOTS];
    rec_t         table_rec [SLOTS];
    logic         match_store = 1'b1;
    slot_result_t expected_results [$];

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;

    keyed_slot_buffer #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[keyed_slot_buffer] ERROR");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        slot_result_t want;
        rec_t         got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[100:4];
            if (expected_results.size() == 0) begin
                note_mismatch("result with nothing pending", 32'(m_tdata[3:0]), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.ok) note_mismatch("ok", 32'(m_tuser), 32'(want.ok));
                if (m_tdata[3:0] !== want.slot)
                    note_mismatch("slot", 32'(m_tdata[3:0]), 32'(want.slot));
                if (got.client_id !== want.rec.client_id)
                    note_mismatch("out_client", 32'(got.client_id),
                                  32'(want.rec.client_id));
                if (got.product_id !== want.rec.product_id)
                    note_mismatch("out_product", 32'(got.product_id),
                                  32'(want.rec.product_id));
                if (got.available !== want.rec.available)
                    note_mismatch("out_available", 32'(got.available),
                                  32'(want.rec.available));
                if (got.store_id !== want.rec.store_id)
                    note_mismatch("out_store", 32'(got.store_id), 32'(want.rec.store_id));
                if (got.assistant_id !== want.rec.assistant_id)
                    note_mismatch("out_assistant", 32'(got.assistant_id),
                                  32'(want.rec.assistant_id));
                if (got.request_stamp !== want.rec.request_stamp)
                    note_mismatch("out_request_stamp", got.request_stamp,
                                  want.rec.request_stamp);
                if (got.order_stamp !== want.rec.order_stamp)
                    note_mismatch("out_order_stamp", got.order_stamp, want.rec.order_stamp);
                if (m_tdata[M_TDATA_W-1:101] !== '0)
                    note_mismatch("m_tdata pad", 32'(m_tdata[M_TDATA_W-1:101]), 0);
            end
        end
    end

    // Works out the result of one request and updates the shadow table.
    task automatic predict_request(input logic cmd, input logic [KEY_W-1:0] key,
                                   input rec_t rec);
        slot_result_t res;
        logic [ID_W-1:0] field;
        res.ok = 1'b0;
        res.slot = '0;
        res.rec = '0;
        if (cmd == CMD_PUT) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!res.ok && !table_used[i]) begin
                    table_used[i] = 1'b1;
                    table_rec[i] = rec;
                    res.ok = 1'b1;
                    res.slot = i[SLOT_W-1:0];
                end
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                field = match_store ? table_rec[i].store_id : table_rec[i].client_id;
                if (!res.ok && table_used[i] && field == key) begin
                    table_used[i] = 1'b0;
                    res.ok = 1'b1;
                    res.slot = i[SLOT_W-1:0];
                    res.rec = table_rec[i];
                end
            end
        end
        expected_results.push_back(res);
    endtask

    // Offers one request and returns at the edge of its transfer, s_tvalid left high.
    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                                input rec_t rec);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'b0, rec, key};
        do @(posedge aclk); while (!s_tready);
        predict_request(cmd, key, rec);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SLOTS + 3) @(posedge aclk);
    endtask

    task automatic write_match_mode(input logic mode);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        match_store = mode;
    endtask

    function automatic rec_t random_rec();
        rec_t rec;
        rec.client_id = 8'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 255));
        rec.product_id = 8'($urandom_range(0, 255));
        rec.available = 1'($urandom_range(0, 1));
        rec.store_id = 8'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 255));
        rec.assistant_id = 8'($urandom_range(0, 255));
        rec.request_stamp = $urandom;
        rec.order_stamp = $urandom;
        return rec;
    endfunction

    // Puts and takes, more puts when the table is near empty; most takes use keys in the table,
    // so the scan reaches deep slots; the rest take random keys, and some puts overflow.
    task automatic send_random_request();
        int used_slots [$];
        int put_pct;
        logic [KEY_W-1:0] key;
        logic cmd;
        int pick;
        for (int i = 0; i < SLOTS; i++) if (table_used[i]) used_slots.push_back(i);
        if (used_slots.size() >= SLOTS - 1) put_pct = 30;
        else if (used_slots.size() <= 1) put_pct = 85;
        else put_pct = 55;
        cmd = ($urandom_range(0, 99) < put_pct) ? CMD_PUT : CMD_TAKE;
        key = 8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
        if (cmd == CMD_TAKE && used_slots.size() > 0 && $urandom_range(0, 99) < 80) begin
            pick = used_slots[$urandom_range(0, used_slots.size() - 1)];
            key = match_store ? table_rec[pick].store_id : table_rec[pick].client_id;
        end
        send_request(cmd, key, random_rec());
    endtask

    task automatic test_empty_take();
        send_request(CMD_TAKE, 8'h00, '0);
    endtask

    task automatic test_fill_and_overflow();
        rec_t rec;
        for (int i = 0; i < SLOTS; i++) begin
            rec = random_rec();
            if (i == 0) begin
                rec = '0;
            end else if (i == 1) begin
                rec = '1;
            end else begin
                rec.store_id = 8'(8'h40 + i % 4);
                rec.client_id = 8'(8'hA0 + i % 3);
            end
            send_request(CMD_PUT, 8'($urandom_range(0, 255)), rec);
        end
        // The table is full now, so this put has to fail.
        send_request(CMD_PUT, 8'hFF, random_rec());
    endtask

    task automatic test_take_by_store();
        rec_t rec;
        send_request(CMD_TAKE, 8'h42, '1);
        send_request(CMD_TAKE, 8'h42, '0);
        send_request(CMD_TAKE, 8'h3F, random_rec());
        send_request(CMD_TAKE, 8'hFF, random_rec());
        rec = random_rec();
        rec.store_id = 8'h5A;
        rec.client_id = 8'h5A;
        send_request(CMD_PUT, 8'h00, rec);
    endtask

    task automatic test_take_by_client();
        send_request(CMD_TAKE, 8'h00, random_rec());
        send_request(CMD_TAKE, 8'hA2, random_rec());
    endtask

    // The receiver stalls long enough for the block to fill up and hold off the sender.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 300;
        repeat (30) send_random_request();
        settle();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            send_random_request();
            // Now and then the sender waits for every result before going on.
            if ($urandom_range(0, 99) == 0) settle();
        end
        settle();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            table_used[i] = 1'b0;
            table_rec[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_take();
        test_fill_and_overflow();
        test_take_by_store();
        settle();
        write_match_mode(1'b0);
        test_take_by_client();
        settle();

        test_random(250, 35, 63);
        write_match_mode(1'b1);
        test_random(250, 63, 35);
        test_output_backpressure();
        write_match_mode(1'b0);
        test_random(75, 0, 0);
        write_match_mode(1'b1);
        test_random(75, 0, 0);
        write_match_mode(1'b0);
        test_random(75, 0, 0);

        if (mismatch_count == 0) begin
            $display("[keyed_slot_buffer] OK");
        end else begin
            $display("[keyed_slot_buffer] ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/ksb_pkg.sv
rtl/ksb_ctrl.sv
rtl/ksb_dp.sv
rtl/keyed_slot_buffer.sv
bench/keyed_slot_buffer_tb.sv
